// ===== src/text_line_pattern_search_defines.svh =====
// ----------------------------------------------------------------------------
// text_line_pattern_search_defines
// Assertion macros shared by the checker of the pattern search block.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_PATTERN_SEARCH_DEFINES_SVH
`define TEXT_LINE_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define TLPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlps assertion failed");

// Next-cycle implication, disabled while reset is high
`define TLPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlps assertion failed");

`endif

// ===== src/tlps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlps_pkg
// Types, constants and helper functions of the line pattern search block.
// ----------------------------------------------------------------------------
package tlps_pkg;

   localparam int unsigned PAT_CHARS  = 16;
   localparam int unsigned PAT_IDX_W  = 4;
   localparam int unsigned CHAR_W     = 16;
   localparam int unsigned LEN_W      = 5;
   localparam int unsigned WORD_W     = 64;
   localparam int unsigned NUM_WORDS  = 4;
   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0000;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 16'h0061;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 16'h007A;
   localparam logic [CHAR_W-1:0] CASE_DELTA = 16'h0020;

   typedef logic [CHAR_W-1:0] char_type;

   typedef enum logic [2:0] {
      REG_PATTERN_0  = 3'd0,
      REG_PATTERN_1  = 3'd1,
      REG_PATTERN_2  = 3'd2,
      REG_PATTERN_3  = 3'd3,
      REG_LENGTH     = 3'd4,
      REG_FOLD_CASE  = 3'd5,
      REG_WHOLE_WORD = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [NUM_WORDS-1:0][WORD_W-1:0] pattern;
      logic [LEN_W-1:0]                 length;
      logic                             fold_case;
      logic                             whole_word;
   } cfg_type;

   typedef struct packed {
      logic advance;
      logic clear;
      logic fold_case;
   } cell_ctl_type;

   // Map an ASCII lower-case letter to upper case when folding is on
   function automatic char_type fold_char(input char_type c, input logic en);
      if (en && (c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
         return c - CASE_DELTA;
      end
      return c;
   endfunction

   // Pick pattern character idx out of the four packed words
   function automatic char_type pattern_char(input logic [NUM_WORDS-1:0][WORD_W-1:0] words,
                                             input logic [PAT_IDX_W-1:0] idx);
      return words[idx[3:2]][{idx[1:0], 4'b0000} +: CHAR_W];
   endfunction

endpackage

// ===== src/tlps_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlps_csr
// APB register file: pattern words, pattern length and the mode bits.
// ----------------------------------------------------------------------------
module tlps_csr
   import tlps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   csr_index_type index;
   logic          write_en;

   assign index      = csr_index_type'(csr_paddr[5:3]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (write_en) begin
         unique case (index)
            REG_PATTERN_0:  cfg_ff.pattern[0] <= csr_pwdata;
            REG_PATTERN_1:  cfg_ff.pattern[1] <= csr_pwdata;
            REG_PATTERN_2:  cfg_ff.pattern[2] <= csr_pwdata;
            REG_PATTERN_3:  cfg_ff.pattern[3] <= csr_pwdata;
            REG_LENGTH:     cfg_ff.length     <= csr_pwdata[LEN_W-1:0];
            REG_FOLD_CASE:  cfg_ff.fold_case  <= csr_pwdata[0];
            REG_WHOLE_WORD: cfg_ff.whole_word <= csr_pwdata[0];
            default: begin
               // unmapped address: drop the write
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_PATTERN_0:  csr_prdata = cfg_ff.pattern[0];
         REG_PATTERN_1:  csr_prdata = cfg_ff.pattern[1];
         REG_PATTERN_2:  csr_prdata = cfg_ff.pattern[2];
         REG_PATTERN_3:  csr_prdata = cfg_ff.pattern[3];
         REG_LENGTH:     csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, cfg_ff.length};
         REG_FOLD_CASE:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.fold_case};
         REG_WHOLE_WORD: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.whole_word};
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ===== src/tlps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlps_cell
// One window slot: holds a character, passes it on, compares the incoming
// character against its pattern character.
// ----------------------------------------------------------------------------
module tlps_cell
   import tlps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  char_type     char_in,
   input  char_type     pat_char,
   input  logic         active,
   output char_type     char_out,
   output logic         hit,
   output logic         is_space
);

   char_type char_ff;
   char_type char_next;

   // Region start empties the window before the shift
   assign char_next = ctl.clear ? CH_ZERO : char_in;
   assign char_out  = char_ff;

   assign hit = !active ||
                (fold_char(char_next, ctl.fold_case) == fold_char(pat_char, ctl.fold_case));
   assign is_space = (char_next == CH_SPACE);

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= CH_ZERO;
      end else if (ctl.advance) begin
         char_ff <= char_next;
      end
   end

endmodule

// ===== src/text_line_pattern_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_pattern_search
// Finds the first match of a configured pattern in a line region, one
// 16-bit character per cycle.
// ----------------------------------------------------------------------------
// The block takes one character item per clock cycle for as long as the
// result side keeps up; the limit is the row of window cells, which compares
// every pattern position against the shifted window in the cycle a character
// is accepted. The result (found flag and match index) is shown in the cycle
// after the item that carries line_last is accepted, from an output register;
// while that result waits, the next item is held off only if the result is
// not taken in the same cycle. Configure the pattern over the APB port while
// the block is idle: registers sit at byte address 8*i, 64 bits wide. There
// is no clearing pass after reset; the block is ready at once.
// ----------------------------------------------------------------------------
module text_line_pattern_search
   import tlps_pkg::*;
#(
   parameter int unsigned PATTERN_MAX = PAT_CHARS
)(
   input  logic                  clock,
   input  logic                  reset,
   // character items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic                  req_region_first,
   input  logic                  req_line_last,
   input  logic [CHAR_W-1:0]     req_base_position,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [CHAR_W-1:0]     rsp_match_index,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned NUM_CELLS = PATTERN_MAX + 1;
   localparam logic [CHAR_W-1:0] POS_MAX = '1;

   cfg_type cfg;

   // search state
   logic [CHAR_W-1:0] pos_ff,   pos_in;
   logic [CHAR_W-1:0] base_ff,  base_in;
   logic              seen_ff,  seen_in;
   logic [CHAR_W-1:0] moff_ff,  moff_in;
   logic              pend_ff,  pend_in;
   logic [CHAR_W-1:0] poff_ff,  poff_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [CHAR_W-1:0] rsp_index_ff, rsp_index_in;

   logic accept;

   // cell row
   cell_ctl_type         ctl_lead, ctl_rest;
   char_type             cell_char [NUM_CELLS];
   logic [NUM_CELLS-1:0] cell_hit;
   logic [NUM_CELLS-1:0] cell_space;

   tlps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Take a new item whenever the output register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // The newest cell never clears: it loads the incoming character whenever an item is accepted
   assign ctl_lead = '{advance: accept, clear: 1'b0, fold_case: cfg.fold_case};
   assign ctl_rest = '{advance: accept, clear: req_region_first, fold_case: cfg.fold_case};

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      logic [LEN_W-1:0] pat_pos;
      logic             active;
      char_type         pat_char;
      char_type         char_in;

      // Cell k holds window entry k, which lines up with pattern char len-1-k
      assign pat_pos  = cfg.length - LEN_W'(k + 1);
      assign active   = (cfg.length > LEN_W'(k));
      assign pat_char = pattern_char(cfg.pattern, pat_pos[PAT_IDX_W-1:0]);

      if (k == 0) begin : g_lead
         assign char_in = req_char_code;
         tlps_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl_lead),
            .char_in  (char_in),
            .pat_char (pat_char),
            .active   (active),
            .char_out (cell_char[k]),
            .hit      (cell_hit[k]),
            .is_space (cell_space[k])
         );
      end else begin : g_rest
         assign char_in = cell_char[k-1];
         tlps_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl_rest),
            .char_in  (char_in),
            .pat_char (pat_char),
            .active   (active),
            .char_out (cell_char[k]),
            .hit      (cell_hit[k]),
            .is_space (cell_space[k])
         );
      end
   end

   // Search control: restart, close pending word, look for a new match, build the result
   always_comb begin
      logic              space_at_len;
      logic              len_ok;
      logic              can_search;
      logic [CHAR_W-1:0] start;
      logic              close_char;

      space_at_len = 1'b0;
      for (int k = 0; k < NUM_CELLS; k++) begin
         if (cfg.length == LEN_W'(k)) begin
            space_at_len = cell_space[k];
         end
      end

      // restart on region start
      pos_in  = req_region_first ? '0 : pos_ff;
      base_in = req_region_first ? req_base_position : base_ff;
      seen_in = req_region_first ? 1'b0 : seen_ff;
      moff_in = req_region_first ? '0 : moff_ff;
      pend_in = req_region_first ? 1'b0 : pend_ff;
      poff_in = req_region_first ? '0 : poff_ff;

      // a pending whole word closes on space or zero
      close_char = (req_char_code == CH_SPACE) || (req_char_code == CH_ZERO);
      if (pend_in) begin
         if (close_char && !seen_in) begin
            seen_in = 1'b1;
            moff_in = poff_in;
         end
         pend_in = 1'b0;
      end

      len_ok = (cfg.length != '0) && (cfg.length <= LEN_W'(PATTERN_MAX));
      can_search = !seen_in && (pos_in != POS_MAX) && len_ok &&
                   (({1'b0, pos_in} + 17'd1) >= {{(CHAR_W+1-LEN_W){1'b0}}, cfg.length});
      start = pos_in + 16'd1 - {{(CHAR_W-LEN_W){1'b0}}, cfg.length};

      if (can_search && (&cell_hit)) begin
         if (!cfg.whole_word) begin
            seen_in = 1'b1;
            moff_in = start;
         end else if ((start == '0) || space_at_len) begin
            if (req_line_last) begin
               seen_in = 1'b1;
               moff_in = start;
            end else begin
               pend_in = 1'b1;
               poff_in = start;
            end
         end
      end

      if (pos_in != POS_MAX) begin
         pos_in = pos_in + 16'd1;
      end

      // report on the last character and drop the line's state
      rsp_found_in = seen_in;
      rsp_index_in = seen_in ? (base_in + moff_in) : '0;
      if (req_line_last) begin
         seen_in = 1'b0;
         moff_in = '0;
         pend_in = 1'b0;
         poff_in = '0;
         pos_in  = '0;
      end

      // hold the result until taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && req_line_last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         base_ff      <= '0;
         seen_ff      <= 1'b0;
         moff_ff      <= '0;
         pend_ff      <= 1'b0;
         poff_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff  <= pos_in;
            base_ff <= base_in;
            seen_ff <= seen_in;
            moff_ff <= moff_in;
            pend_ff <= pend_in;
            poff_ff <= poff_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload: load only when a new result is issued
   always_ff @(posedge clock) begin
      if (accept && req_line_last) begin
         rsp_found_ff <= rsp_found_in;
         rsp_index_ff <= rsp_index_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;

endmodule

// ===== src/tlps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlps_checker
// Port-level checks of the line pattern search block, bound to the top.
// ----------------------------------------------------------------------------
`include "text_line_pattern_search_defines.svh"

module tlps_checker
   import tlps_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_line_last,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_found,
   input logic [CHAR_W-1:0]     rsp_match_index
);

   // a stalled result holds
   `TLPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_found) && $stable(rsp_match_index))

   // last character of a line yields a result in the next cycle
   `TLPS_ASSERT_NEXT(a_last_gives_rsp, clock, reset, req_valid && req_ready && req_line_last,
      rsp_valid)

   // no match reports index zero
   `TLPS_ASSERT_SAME(a_miss_index_zero, clock, reset, rsp_valid && !rsp_found,
      rsp_match_index == '0)

   // a waiting result blocks new items
   `TLPS_ASSERT_SAME(a_no_overrun, clock, reset, rsp_valid && !rsp_ready, !req_ready)

endmodule

bind text_line_pattern_search tlps_checker u_tlps_checker (.*);
